>>> hdl/sers_pkg.sv
package sers_pkg;

  localparam int CHANNELS      = 6;
  localparam int REAR_CHANNELS = 3;
  localparam int KIND_W        = 2;
  localparam int LEVEL_W       = CHANNELS;
  localparam int ECHO_TIME_W   = 16;
  localparam int ACTION_W      = 3;
  localparam int RANGE_W       = 16;
  localparam int SUM_W         = 18;
  localparam int SEC_W         = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 18;

  localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

  // x / 3 for x below 2**19 as (x * ceil(2**20 / 3)) >> 20
  localparam int DIV3_IN_W  = 18;
  localparam int DIV3_SHIFT = 20;
  localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = 20'd349526;

  localparam logic [RANGE_W-1:0] NEAR_RESET = 16'd300;
  localparam logic [SUM_W-1:0]   SUM_RESET  = 18'd900;
  localparam logic [SEC_W-1:0]   HOLD_RESET = 16'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_DECIDE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_STOP     = 3'd0,
    ACT_FORWARD  = 3'd1,
    ACT_TURN     = 3'd2,
    ACT_REVERSE  = 3'd3,
    ACT_TURN_INV = 3'd4
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE = 2'd0,
    REG_NEAR = 2'd1,
    REG_SUM  = 2'd2,
    REG_HOLD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range0;
    logic [SUM_W-1:0]   front_sum;
    logic [SUM_W-1:0]   rear_sum;
    logic [SEC_W-1:0]   seconds;
  } track_status_t;

  function automatic action_t choose_action(
    input logic               mode,
    input logic [RANGE_W-1:0] near_thr,
    input logic [SUM_W-1:0]   sum_thr,
    input logic [SEC_W-1:0]   hold,
    input track_status_t      st
  );
    action_t act;
    priority if (st.seconds < hold) begin
      act = ACT_STOP;
    end else if (!mode) begin
      act = (st.range0 > near_thr) ? ACT_FORWARD : ACT_TURN;
    end else if (st.front_sum > st.rear_sum) begin
      act = (st.front_sum > sum_thr) ? ACT_FORWARD : ACT_TURN;
    end else begin
      act = (st.rear_sum > sum_thr) ? ACT_REVERSE : ACT_TURN_INV;
    end
    return act;
  endfunction

endpackage

>>> hdl/sers_if.sv
interface sers_in_if import sers_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [LEVEL_W-1:0]     echo_levels;
  logic [ECHO_TIME_W-1:0] echo_time;

  modport source (output valid, kind, echo_levels, echo_time, input ready);
  modport sink   (input valid, kind, echo_levels, echo_time, output ready);
endinterface

interface sers_out_if import sers_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SUM_W-1:0]    front_sum;
  logic [SUM_W-1:0]    rear_sum;

  modport source (output valid, action, front_sum, rear_sum, input ready);
  modport sink   (input valid, action, front_sum, rear_sum, output ready);
endinterface

interface sers_cfg_if import sers_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sers_track.sv
module sers_track import sers_pkg::*; #(
  parameter int RANGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  sample_en,
  input  logic                  tick_en,
  input  logic [CHANNELS-1:0]   levels,
  input  logic [RANGE_BITS-1:0] echo_t,
  output track_status_t         status
);

  logic [CHANNELS-1:0]   was_high_r;
  logic [RANGE_BITS-1:0] range_r   [CHANNELS];
  logic [RANGE_BITS-1:0] range_nxt [CHANNELS];
  logic [SEC_W-1:0]      seconds_r;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    if (i < REAR_CHANNELS) begin : g_smooth
      logic [DIV3_IN_W-1:0]            acc;
      logic [DIV3_IN_W+DIV3_SHIFT-1:0] prod;
      // (capture + 2*old) / 3 by reciprocal multiply
      assign acc  = DIV3_IN_W'(echo_t) + DIV3_IN_W'({range_r[i], 1'b0});
      assign prod = {{DIV3_SHIFT{1'b0}}, acc} * {{DIV3_IN_W{1'b0}}, DIV3_MUL};
      assign range_nxt[i] = prod[DIV3_SHIFT +: RANGE_BITS];
    end else begin : g_raw
      assign range_nxt[i] = echo_t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        range_r[i] <= '0;
      end else if (sample_en && was_high_r[i] && !levels[i]) begin
        range_r[i] <= range_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_high_r <= '0;
      seconds_r  <= '0;
    end else begin
      if (sample_en) begin
        was_high_r <= levels;
      end
      if (tick_en && seconds_r != SEC_MAX) begin
        seconds_r <= seconds_r + SEC_W'(1);
      end
    end
  end

  always_comb begin
    status.range0    = RANGE_W'(range_r[0]);
    status.rear_sum  = SUM_W'(range_r[0]) + SUM_W'(range_r[1]) + SUM_W'(range_r[2]);
    status.front_sum = SUM_W'(range_r[3]) + SUM_W'(range_r[4]) + SUM_W'(range_r[5]);
    status.seconds   = seconds_r;
  end

endmodule

>>> hdl/sonar_echo_ranging_steering_top.sv
// six-line sonar ranging with a steering decision
// in_ch carries items: kind selects echo sample, decision request or one-second tick;
// an echo sample captures echo_time on every line that fell since the previous sample,
// lines 0 to 2 smoothed as (capture + 2*old)/3, lines 3 to 5 raw
// out_ch gives one transfer per decision request: action, front and rear group sums
// cfg_ch writes steer_mode, near_threshold, sum_threshold, hold_seconds (index 0 to 3),
// always ready, and is meant to be written while no item is in flight
// order: an item is held in the input register and applied to the channel state from there;
// a decision result is then registered in the output register
// throughput: one item per cycle unless a decision request waits on a stalled output,
// set by the single input register feeding the channel state and the output register
// when out_ch stalls, samples and ticks keep flowing; a decision request waits in the
// input register until the output register frees, and in_ch.ready drops only then
// reset clears line levels, ranges and the seconds count, loads the register defaults
// and empties both pipeline registers
module sonar_echo_ranging_steering_top import sers_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  sers_in_if.sink           in_ch,
  sers_out_if.source        out_ch,
  sers_cfg_if.sink          cfg_ch
);

  localparam int RW = (TIME_WIDTH < ECHO_TIME_W) ? TIME_WIDTH : ECHO_TIME_W;

  logic               mode_r;
  logic [RANGE_W-1:0] near_r;
  logic [SUM_W-1:0]   sum_thr_r;
  logic [SEC_W-1:0]   hold_r;

  logic               stage_valid_r, stage_valid_nxt;
  logic [KIND_W-1:0]  stage_kind_r;
  logic [LEVEL_W-1:0] stage_levels_r;
  logic [RW-1:0]      stage_time_r;

  logic               out_valid_r, out_valid_nxt;
  action_t            out_action_r;
  logic [SUM_W-1:0]   out_front_r;
  logic [SUM_W-1:0]   out_rear_r;

  logic               in_xfer, out_free, stage_adv, out_load;
  logic               sample_en, tick_en;
  track_status_t      status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      near_r    <= NEAR_RESET;
      sum_thr_r <= SUM_RESET;
      hold_r    <= HOLD_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_MODE: mode_r    <= cfg_ch.data[0];
        REG_NEAR: near_r    <= cfg_ch.data[RANGE_W-1:0];
        REG_SUM:  sum_thr_r <= cfg_ch.data[SUM_W-1:0];
        REG_HOLD: hold_r    <= cfg_ch.data[SEC_W-1:0];
      endcase
    end
  end

  // handshake: a decision request only leaves the stage when the output register frees
  always_comb begin
    out_free  = !out_valid_r || out_ch.ready;
    stage_adv = stage_valid_r && (stage_kind_r != KIND_DECIDE || out_free);
    out_load  = stage_valid_r && stage_kind_r == KIND_DECIDE && out_free;
    sample_en = stage_adv && stage_kind_r == KIND_SAMPLE;
    tick_en   = stage_adv && stage_kind_r == KIND_TICK;
    in_xfer   = in_ch.valid && in_ch.ready;
    stage_valid_nxt = in_xfer || (stage_valid_r && !stage_adv);
    out_valid_nxt   = out_load || (out_valid_r && !out_ch.ready);
  end

  assign in_ch.ready = !stage_valid_r || stage_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_kind_r   <= in_ch.kind;
      stage_levels_r <= in_ch.echo_levels;
      stage_time_r   <= in_ch.echo_time[RW-1:0];
    end
    if (out_load) begin
      out_action_r <= choose_action(mode_r, near_r, sum_thr_r, hold_r, status);
      out_front_r  <= status.front_sum;
      out_rear_r   <= status.rear_sum;
    end
  end

  sers_track #(
    .RANGE_BITS (RW)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .tick_en   (tick_en),
    .levels    (stage_levels_r),
    .echo_t    (stage_time_r),
    .status    (status)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.action    = out_action_r;
  assign out_ch.front_sum = out_front_r;
  assign out_ch.rear_sum  = out_rear_r;

  a_hold_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (status.seconds < hold_r) |=> out_action_r == ACT_STOP)
    else $error("decision inside hold period not stop");

  a_rear_wins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_action_r == ACT_REVERSE || out_action_r == ACT_TURN_INV)
      |-> out_rear_r >= out_front_r)
    else $error("rear action with front sum ahead");

  a_seconds_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> status.seconds >= $past(status.seconds))
    else $error("seconds count went backwards");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stage_valid_r && stage_kind_r == KIND_DECIDE && out_valid_r
      && !out_ch.ready)
    else $error("input stalled without a blocked decision");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sers_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 965;
  localparam int PHASE_ITEMS     = 150;
  localparam int DRAIN_CYCLES    = 4;

  typedef struct {
    action_t          action;
    logic [SUM_W-1:0] front_sum;
    logic [SUM_W-1:0] rear_sum;
  } steer_result_t;

  logic clk;
  logic rst_n;

  sers_in_if  in_ch ();
  sers_out_if out_ch ();
  sers_cfg_if cfg_ch ();

  sonar_echo_ranging_steering_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // own copy of the sonar state and registers
  logic               line_high [CHANNELS];
  logic [RANGE_W-1:0] range_q [CHANNELS];
  logic [SEC_W-1:0]   sec_q;
  logic               mode_q;
  logic [RANGE_W-1:0] near_q;
  logic [SUM_W-1:0]   sum_thr_q;
  logic [SEC_W-1:0]   hold_q;

  steer_result_t pending_steer [$];
  int            err_cnt = 0;
  bit            in_gaps_on = 1'b1;
  bit            out_stall_on = 1'b1;
  logic          out_hold;
  event          hold_kick;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic advance_sonar(input logic [KIND_W-1:0] k, input logic [LEVEL_W-1:0] lv,
                               input logic [ECHO_TIME_W-1:0] t);
    int i;
    logic [SUM_W-1:0] smoothed;
    steer_result_t res;
    case (k)
      KIND_SAMPLE: begin
        for (i = 0; i < CHANNELS; i++) begin
          if (line_high[i] && !lv[i]) begin
            if (i < REAR_CHANNELS) begin
              smoothed = SUM_W'((SUM_W'(t) + 2 * SUM_W'(range_q[i])) / 3);
              range_q[i] = smoothed[RANGE_W-1:0];
            end else begin
              range_q[i] = t;
            end
          end
          line_high[i] = lv[i];
        end
      end
      KIND_TICK: begin
        if (sec_q != SEC_MAX) sec_q++;
      end
      KIND_DECIDE: begin
        res.rear_sum  = SUM_W'(range_q[0]) + range_q[1] + range_q[2];
        res.front_sum = SUM_W'(range_q[3]) + range_q[4] + range_q[5];
        if (sec_q < hold_q) begin
          res.action = ACT_STOP;
        end else if (!mode_q) begin
          res.action = (range_q[0] > near_q) ? ACT_FORWARD : ACT_TURN;
        end else if (res.front_sum > res.rear_sum) begin
          res.action = (res.front_sum > sum_thr_q) ? ACT_FORWARD : ACT_TURN;
        end else begin
          res.action = (res.rear_sum > sum_thr_q) ? ACT_REVERSE : ACT_TURN_INV;
        end
        pending_steer.push_back(res);
      end
      default: ;
    endcase
  endtask

  // valid stays high after the transfer; the next call or settle() decides what follows
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [LEVEL_W-1:0] lv,
                           input logic [ECHO_TIME_W-1:0] t);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.echo_levels <= lv;
    in_ch.echo_time   <= t;
    do @(posedge clk); while (!in_ch.ready);
    advance_sonar(k, lv, t);
  endtask

  task automatic ask_decision();
    send_item(KIND_DECIDE, LEVEL_W'($urandom()), ECHO_TIME_W'($urandom()));
  endtask

  task automatic second_tick();
    send_item(KIND_TICK, LEVEL_W'($urandom()), ECHO_TIME_W'($urandom()));
  endtask

  // samples and ticks give no result, so give the pipeline time to empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MODE: mode_q    = val[0];
      REG_NEAR: near_q    = val[RANGE_W-1:0];
      REG_SUM:  sum_thr_q = val[SUM_W-1:0];
      REG_HOLD: hold_q    = val[SEC_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] cfg_value(input cfg_reg_t idx);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom());
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = (idx == REG_SUM) ? 18'd196605 : 18'h0FFFF;
      3, 4: begin
        if (idx == REG_HOLD) v = CFG_DATA_W'($urandom_range(0, 120));
        else if (idx == REG_NEAR) v = CFG_DATA_W'($urandom_range(0, 40000));
        else if (idx == REG_SUM) v = CFG_DATA_W'($urandom_range(0, 196605));
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_after_reset();
    ask_decision();
    send_item(KIND_UNUSED, '1, '1);   // must not store the levels
    send_item(KIND_SAMPLE, '0, '1);
    send_item(KIND_SAMPLE, '1, '0);
    send_item(KIND_SAMPLE, '0, '1);   // every line falls at full count
    send_item(KIND_SAMPLE, '0, '0);
    ask_decision();
  endtask

  task automatic test_hold_period();
    repeat (9) second_tick();
    ask_decision();
    second_tick();
    ask_decision();
    write_reg(REG_HOLD, 18'h0FFFF);
    ask_decision();
    write_reg(REG_HOLD, '0);
    ask_decision();
  endtask

  task automatic test_single_sensor_rule();
    write_reg(REG_MODE, 18'h3FFFE);   // upper data bits ignored
    write_reg(REG_NEAR, '0);
    ask_decision();
    write_reg(REG_NEAR, 18'h3FFFF);
    ask_decision();
    write_reg(REG_NEAR, CFG_DATA_W'(range_q[0]));  // equal is not above
    ask_decision();
    write_reg(REG_NEAR, CFG_DATA_W'(range_q[0]) - CFG_DATA_W'(1));
    ask_decision();
  endtask

  task automatic test_group_sums();
    write_reg(REG_MODE, 18'd1);
    write_reg(REG_SUM, 18'd196605);
    ask_decision();
    write_reg(REG_SUM, '0);
    ask_decision();
    // front lines capture the rear range so both sums tie
    send_item(KIND_SAMPLE, 6'h38, '0);
    send_item(KIND_SAMPLE, '0, range_q[0]);
    ask_decision();
    write_reg(REG_SUM, '1);
    ask_decision();
    send_item(KIND_SAMPLE, 6'h38, '1);
    send_item(KIND_SAMPLE, '0, '0);
    ask_decision();
    send_item(KIND_SAMPLE, 6'h38, '0);
    send_item(KIND_SAMPLE, '0, '1);
    write_reg(REG_SUM, 18'd196604);
    ask_decision();
  endtask

  task automatic test_random_traffic();
    int n;
    int unsigned pick;
    logic [LEVEL_W-1:0] levels;
    logic [ECHO_TIME_W-1:0] t;
    levels = '0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        in_gaps_on   = $urandom_range(0, 3) != 0;
        out_stall_on = $urandom_range(0, 3) != 0;
        write_reg(REG_MODE, CFG_DATA_W'($urandom()));
        write_reg(REG_NEAR, cfg_value(REG_NEAR));
        write_reg(REG_SUM, cfg_value(REG_SUM));
        write_reg(REG_HOLD, cfg_value(REG_HOLD));
      end
      case ($urandom_range(0, 9))
        0: t = '0;
        1: t = '1;
        default: t = ECHO_TIME_W'($urandom());
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // mostly a few lines change per sample, now and then pure noise
        if (pick < 6) levels = LEVEL_W'($urandom());
        else levels = levels ^ (LEVEL_W'($urandom()) & LEVEL_W'($urandom()));
        send_item(KIND_SAMPLE, levels, t);
      end else if (pick < 85) begin
        send_item(KIND_DECIDE, LEVEL_W'($urandom()), t);
      end else if (pick < 95) begin
        send_item(KIND_TICK, LEVEL_W'($urandom()), t);
      end else begin
        send_item(KIND_UNUSED, LEVEL_W'($urandom()), t);
      end
    end
  endtask

  task automatic test_output_hold_off();
    int n;
    write_reg(REG_MODE, 18'd1);
    write_reg(REG_HOLD, '0);
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    -> hold_kick;
    for (n = 0; n < 48; n++) begin
      if (n % 4 == 3) ask_decision();
      else send_item(KIND_SAMPLE, LEVEL_W'($urandom()), ECHO_TIME_W'($urandom()));
    end
    settle();
  endtask

  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) stall_left = out_stall_on ? $urandom_range(0, 15) : 0;
      else if (stall_left != 0) stall_left--;
      out_ch.ready <= rst_n && !out_hold && stall_left == 0;
    end
  end

  initial begin : hold_off
    out_hold <= 1'b0;
    forever begin
      @(hold_kick);
      out_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      out_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    steer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_steer.size() == 0) begin
        $error("unexpected transfer: action %0d front_sum %0d rear_sum %0d",
               out_ch.action, out_ch.front_sum, out_ch.rear_sum);
        err_cnt++;
      end else begin
        want = pending_steer.pop_front();
        if (out_ch.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_ch.action);
          err_cnt++;
        end
        if (out_ch.front_sum !== want.front_sum) begin
          $error("front_sum: expected %0d, got %0d", want.front_sum, out_ch.front_sum);
          err_cnt++;
        end
        if (out_ch.rear_sum !== want.rear_sum) begin
          $error("rear_sum: expected %0d, got %0d", want.rear_sum, out_ch.rear_sum);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : run_tests
    int i;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_SAMPLE;
    in_ch.echo_levels <= '0;
    in_ch.echo_time   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_MODE;
    cfg_ch.data       <= '0;
    for (i = 0; i < CHANNELS; i++) begin
      line_high[i] = 1'b0;
      range_q[i]   = '0;
    end
    sec_q     = '0;
    mode_q    = 1'b0;
    near_q    = NEAR_RESET;
    sum_thr_q = SUM_RESET;
    hold_q    = HOLD_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_hold_period();
    test_single_sensor_rule();
    test_group_sums();
    test_random_traffic();
    test_output_hold_off();

    settle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
